FILE: hdl/lcdt_pkg.sv
// Shared types and constants of the LCD line and mode timer.
// No dependencies; used by lcdt_step and lcd_line_and_mode_timer_unit.
package lcdt_pkg;

  localparam int unsigned LINE_PERIOD   = 456;
  localparam int unsigned VBLANK_LINE   = 144;
  localparam int unsigned LAST_LINE     = 153;
  localparam int unsigned OAM_DOTS      = 80;
  localparam int unsigned TRANSFER_DOTS = 172;

  localparam int unsigned DOT_W  = 10;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned ELAP_W = 6;

  localparam logic [DOT_W-1:0]  DOT_RELOAD = DOT_W'(LINE_PERIOD);
  localparam logic [DOT_W-1:0]  OAM_BOUND  = DOT_W'(LINE_PERIOD - OAM_DOTS);
  localparam logic [DOT_W-1:0]  XFER_BOUND =
      DOT_W'(LINE_PERIOD - OAM_DOTS - TRANSFER_DOTS);
  localparam logic [LINE_W-1:0] VBLANK_LN  = LINE_W'(VBLANK_LINE);
  localparam logic [LINE_W-1:0] LAST_LN    = LINE_W'(LAST_LINE);

  // Configuration register indexes.
  localparam logic [1:0] CFG_LCD_ON       = 2'd0;
  localparam logic [1:0] CFG_LINE_COMPARE = 2'd1;
  localparam logic [1:0] CFG_IRQ_ENABLES  = 2'd2;

  // Bits of the status interrupt enable register.
  localparam int unsigned EN_HBLANK = 0;
  localparam int unsigned EN_VBLANK = 1;
  localparam int unsigned EN_OAM    = 2;
  localparam int unsigned EN_COIN   = 3;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM      = 2'd2,
    MODE_TRANSFER = 2'd3
  } lcd_mode_e;

  typedef struct packed {
    logic              lcd_on;
    logic [LINE_W-1:0] line_compare;
    logic [3:0]        irq_en;
  } cfg_t;

  typedef struct packed {
    logic [DOT_W-1:0]  dots;
    logic [LINE_W-1:0] line;
    lcd_mode_e         mode;
  } timer_state_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic              draw_valid;
    logic              vblank_irq;
    logic              lcd_irq;
    logic              coincidence;
    lcd_mode_e         lcd_mode;
  } result_t;

endpackage

FILE: hdl/lcdt_step.sv
// Next-state and result logic for one beat of the LCD line and mode timer.
// Depends on lcdt_pkg.
module lcdt_step (
  input  lcdt_pkg::cfg_t                 cfg_i,
  input  lcdt_pkg::timer_state_t         state_i,
  input  logic [lcdt_pkg::ELAP_W-1:0]    elapsed_i,
  output lcdt_pkg::timer_state_t         state_o,
  output lcdt_pkg::result_t              result_o
);
  import lcdt_pkg::*;

  lcd_mode_e         mode;
  logic              req;
  logic              coin;
  logic [LINE_W-1:0] line_w;
  logic [LINE_W-1:0] next_line;
  logic              run_out;

  always_comb begin
    // Mode is taken from the line and dot count before this beat advances them.
    if (state_i.line >= VBLANK_LN) begin
      mode = MODE_VBLANK;
      req  = cfg_i.irq_en[EN_VBLANK];
    end else if (state_i.dots >= OAM_BOUND) begin
      mode = MODE_OAM;
      req  = cfg_i.irq_en[EN_OAM];
    end else if (state_i.dots >= XFER_BOUND) begin
      mode = MODE_TRANSFER;
      req  = 1'b0;
    end else begin
      mode = MODE_HBLANK;
      req  = cfg_i.irq_en[EN_HBLANK];
    end

    coin      = (state_i.line == cfg_i.line_compare);
    line_w    = (state_i.line > LAST_LN) ? '0 : state_i.line;
    next_line = line_w + LINE_W'(1);
    run_out   = ({{(DOT_W-ELAP_W){1'b0}}, elapsed_i} >= state_i.dots);

    result_o.lcd_mode    = mode;
    result_o.coincidence = coin;
    result_o.lcd_irq     = (req && (state_i.mode != mode)) ||
                           (coin && cfg_i.irq_en[EN_COIN]);
    result_o.vblank_irq  = 1'b0;
    result_o.draw_valid  = 1'b0;

    state_o.mode = mode;
    if (run_out) begin
      state_o.dots         = DOT_RELOAD;
      state_o.line         = (next_line > LAST_LN) ? '0 : next_line;
      result_o.vblank_irq  = (next_line == VBLANK_LN);
      result_o.draw_valid  = (next_line < VBLANK_LN);
    end else begin
      state_o.dots = state_i.dots - {{(DOT_W-ELAP_W){1'b0}}, elapsed_i};
      state_o.line = line_w;
    end

    // A disabled display parks the timer at the top of the frame in vblank.
    if (!cfg_i.lcd_on) begin
      state_o.dots         = DOT_RELOAD;
      state_o.line         = '0;
      state_o.mode         = MODE_VBLANK;
      result_o.lcd_mode    = MODE_VBLANK;
      result_o.coincidence = 1'b0;
      result_o.lcd_irq     = 1'b0;
      result_o.vblank_irq  = 1'b0;
      result_o.draw_valid  = 1'b0;
    end
    result_o.line_number = state_o.line;
  end

endmodule

FILE: hdl/lcd_line_and_mode_timer_unit.sv
// Top level of the LCD line and mode timer: stream ports, configuration
// registers, input and result registers. Depends on lcdt_pkg and lcdt_step.
//
//   Channel   Direction  Payload
//   s_axis    in         elapsed machine cycles, one beat per report
//   m_axis    out        mode, coincidence, irq flags, draw flag, line
//   cfg       in         lcd_on, line_compare, status_irq_enables writes
//
// One beat is taken every clock while m_axis is not stalled. m_axis_tvalid
// rises once an accepted beat has passed the input register and then the
// result register. The combinational update of the line and dot counters
// lets a new beat enter while the last one is still in the result register.
// After reset the display is on, the line is 0 and 456 dots remain.
// A stall on m_axis holds the result; the input register still fills, and
// only then does s_axis_tready fall.
module lcd_line_and_mode_timer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] elapsed_cycles, [7:6] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] lcd_mode, [2] coincidence,
                                      // [3] lcd_irq, [4] vblank_irq,
                                      // [5] draw_valid, [13:6] line_number,
                                      // [15:14] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import lcdt_pkg::*;

  cfg_t              cfg_q;
  timer_state_t      st_q;
  timer_state_t      st_d;
  result_t           res_d;
  result_t           res_q;
  logic              in_vld_q;
  logic [ELAP_W-1:0] elap_q;
  logic              out_vld_q;
  logic              advance;
  logic              take_in;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lcd_on       <= 1'b1;
      cfg_q.line_compare <= '0;
      cfg_q.irq_en       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LCD_ON:       cfg_q.lcd_on       <= cfg_data_i[0];
        CFG_LINE_COMPARE: cfg_q.line_compare <= cfg_data_i;
        CFG_IRQ_ENABLES:  cfg_q.irq_en       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  lcdt_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (st_q),
    .elapsed_i (elap_q),
    .state_o   (st_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q.dots <= DOT_RELOAD;
      st_q.line <= '0;
      st_q.mode <= MODE_HBLANK;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (in_vld_q && advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      elap_q <= s_axis_tdata[ELAP_W-1:0];
    end
    if (in_vld_q && advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q.line_number, res_q.draw_valid, res_q.vblank_irq,
                          res_q.lcd_irq, res_q.coincidence, res_q.lcd_mode};

  // The counters only ever hold a line in the frame and a nonzero dot count.
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.line <= LAST_LN)
    else $error("line counter beyond last line");

  a_dots_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.dots != '0 && st_q.dots <= DOT_RELOAD)
    else $error("dot countdown out of range");

  a_vblank_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.vblank_irq |-> res_q.line_number == VBLANK_LN)
    else $error("vblank request off the vblank line");

  a_draw_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.draw_valid |-> res_q.line_number < VBLANK_LN)
    else $error("draw request on an invisible line");

  a_lcd_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && advance && !cfg_q.lcd_on |=>
      st_q.line == '0 && st_q.mode == MODE_VBLANK)
    else $error("disabled display did not park the timer");

endmodule
